// ----- rtl/core/rtfr_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rtfr_pkg
// Shared types, codes and helpers of the radio transmit packet framer.
// ----------------------------------------------------------------------------
package rtfr_pkg;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam int OFF_W      = 9;

    localparam logic [OFF_W-1:0] OFF_MAX = '1;

    localparam logic       OP_TICK  = 1'b0;
    localparam logic       OP_START = 1'b1;

    localparam logic [7:0] PREAMBLE_BYTE = 8'h55;

    localparam logic [1:0] ST_SENT      = 2'd0;
    localparam logic [1:0] ST_UNDERFLOW = 2'd1;
    localparam logic [1:0] ST_NONE      = 2'd2;

    localparam logic [2:0] ACT_NONE      = 3'd0;
    localparam logic [2:0] ACT_IDLE      = 3'd1;
    localparam logic [2:0] ACT_CALIBRATE = 3'd2;
    localparam logic [2:0] ACT_FSTXON    = 3'd3;
    localparam logic [2:0] ACT_RX        = 3'd4;
    localparam logic [2:0] ACT_RESTART   = 3'd5;

    localparam logic [1:0] LEN_FIXED    = 2'd0;
    localparam logic [1:0] LEN_VARIABLE = 2'd1;

    localparam logic [1:0] TXOFF_IDLE    = 2'd0;
    localparam logic [1:0] TXOFF_FSTXON  = 2'd1;
    localparam logic [1:0] TXOFF_RESTART = 2'd2;
    localparam logic [1:0] TXOFF_RX      = 2'd3;

    localparam logic [1:0] SYNC_NONE   = 2'd0;
    localparam logic [1:0] SYNC_DOUBLE = 2'd3;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_PREAMBLE_SELECT = 3'd0,
        REG_SYNC_MODE       = 3'd1,
        REG_SYNC_WORD       = 3'd2,
        REG_LENGTH_MODE     = 3'd3,
        REG_PACKET_LENGTH   = 3'd4,
        REG_CHECKSUM_ENABLE = 3'd5,
        REG_TX_OFF_MODE     = 3'd6,
        REG_AUTOCAL_MODE    = 3'd7
    } t_reg_idx;

    typedef enum logic [4:0] {
        PH_PRE  = 5'b00001,
        PH_SYNC = 5'b00010,
        PH_DATA = 5'b00100,
        PH_SUM  = 5'b01000,
        PH_DONE = 5'b10000
    } t_phase;

    typedef struct packed {
        logic [2:0]  preamble_select;
        logic [2:0]  sync_mode;
        logic [15:0] sync_word;
        logic [1:0]  length_mode;
        logic [7:0]  packet_length;
        logic        checksum_enable;
        logic [1:0]  tx_off_mode;
        logic [1:0]  autocal_mode;
    } t_cfg;

    typedef struct packed {
        logic       opcode;
        logic       fifo_has_byte;
        logic [7:0] fifo_byte;
    } t_item;

    typedef struct packed {
        logic [7:0] out_byte;
        logic [1:0] status;
        logic       fifo_pop;
        logic       packet_end;
        logic [2:0] end_action;
    } t_result;

    function automatic logic [4:0] pre_count(input logic [2:0] sel);
        case (sel)
            3'd0:    pre_count = 5'd2;
            3'd1:    pre_count = 5'd3;
            3'd2:    pre_count = 5'd4;
            3'd3:    pre_count = 5'd6;
            3'd4:    pre_count = 5'd8;
            3'd5:    pre_count = 5'd12;
            3'd6:    pre_count = 5'd16;
            default: pre_count = 5'd24;
        endcase
    endfunction

    function automatic logic [OFF_W-1:0] off_inc(input logic [OFF_W-1:0] v);
        off_inc = (v == OFF_MAX) ? OFF_MAX : v + 1'b1;
    endfunction

endpackage

// ----- rtl/core/rtfr_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rtfr_if
// Valid/ready channels of the framer: request items in, result items out.
// ----------------------------------------------------------------------------
interface rtfr_req_if;
    logic       valid;
    logic       ready;
    logic       opcode;
    logic       fifo_has_byte;
    logic [7:0] fifo_byte;

    modport source (output valid, opcode, fifo_has_byte, fifo_byte, input ready);
    modport sink   (input valid, opcode, fifo_has_byte, fifo_byte, output ready);
endinterface

interface rtfr_rsp_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic [1:0] status;
    logic       fifo_pop;
    logic       packet_end;
    logic [2:0] end_action;

    modport source (output valid, out_byte, status, fifo_pop, packet_end, end_action,
                    input ready);
    modport sink   (input valid, out_byte, status, fifo_pop, packet_end, end_action,
                    output ready);
endinterface

// ----- rtl/core/radio_tx_packet_framer_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// radio_tx_packet_framer_top
// Transmit framer of a packet radio: preamble, sync word, payload, byte sum.
// ----------------------------------------------------------------------------
// usage
//   i_req carries one request per byte time: a start (opcode 1) or a tick
//   (opcode 0) together with the head of the transmit fifo. o_rsp returns
//   exactly one result per request: the byte sent, a status, whether the
//   fifo head was consumed, and the end action when the packet closes.
//   configuration registers are written on i_cfg_we with i_cfg_idx and
//   i_cfg_data while no request is in flight.
// timing
//   a request enters an input register, the framer step runs between that
//   register and the result register, which drives o_rsp; one request per
//   cycle is taken in steady state, while o_rsp.ready stays high.
// reset
//   synchronous active-low i_rst_n empties both registers, loads register
//   defaults and leaves the framer in the done phase.
// stall
//   while o_rsp.ready is low the result holds; one more request waits in
//   the input register, after which i_req.ready drops.
// ----------------------------------------------------------------------------
module radio_tx_packet_framer_top (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    rtfr_req_if.sink                        i_req,
    rtfr_rsp_if.source                      o_rsp,
    input  logic                            i_cfg_we,
    input  logic [rtfr_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [rtfr_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    rtfr_pkg::t_cfg    cfg;
    rtfr_pkg::t_result step_res;

    logic              r_in_valid;
    rtfr_pkg::t_item   r_in_item;
    logic              r_out_valid;
    rtfr_pkg::t_result r_out_res;
    logic              advance;

    assign advance     = r_in_valid && (!r_out_valid || o_rsp.ready);
    assign i_req.ready = !r_in_valid || advance;

    rtfr_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (i_cfg_we),
        .i_idx   (i_cfg_idx),
        .i_data  (i_cfg_data),
        .o_cfg   (cfg)
    );

    rtfr_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (advance),
        .i_item   (r_in_item),
        .i_cfg    (cfg),
        .o_result (step_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_req.ready) begin
            r_in_valid <= i_req.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.ready && i_req.valid) begin
            r_in_item.opcode        <= i_req.opcode;
            r_in_item.fifo_has_byte <= i_req.fifo_has_byte;
            r_in_item.fifo_byte     <= i_req.fifo_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (!r_out_valid || o_rsp.ready) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out_res <= step_res;
        end
    end

    assign o_rsp.valid      = r_out_valid;
    assign o_rsp.out_byte   = r_out_res.out_byte;
    assign o_rsp.status     = r_out_res.status;
    assign o_rsp.fifo_pop   = r_out_res.fifo_pop;
    assign o_rsp.packet_end = r_out_res.packet_end;
    assign o_rsp.end_action = r_out_res.end_action;

    // a waiting request is neither dropped nor overwritten
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && !advance |=> r_in_valid && $stable(r_in_item))
        else $error("input register lost a waiting request");

    // end action only with packet end
    a_end_action: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp.valid |-> ((o_rsp.end_action != rtfr_pkg::ACT_NONE) == o_rsp.packet_end))
        else $error("end action without packet end");

    // a fifo pop always sends that byte
    a_pop_sent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp.valid && o_rsp.fifo_pop |-> o_rsp.status == rtfr_pkg::ST_SENT)
        else $error("fifo pop without a sent byte");

    // no byte value when nothing is sent
    a_idle_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp.valid && o_rsp.status != rtfr_pkg::ST_SENT |-> o_rsp.out_byte == 8'h00)
        else $error("byte value on a result with nothing sent");

endmodule

// ----- rtl/core/rtfr_cfg_regs.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rtfr_cfg_regs
// Configuration register file, written through a plain write port.
// ----------------------------------------------------------------------------
module rtfr_cfg_regs (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_we,
    input  logic [rtfr_pkg::CFG_IDX_W-1:0]  i_idx,
    input  logic [rtfr_pkg::CFG_DATA_W-1:0] i_data,
    output rtfr_pkg::t_cfg                  o_cfg
);

    rtfr_pkg::t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.preamble_select <= 3'd2;
            r_cfg.sync_mode       <= 3'd2;
            r_cfg.sync_word       <= 16'hD9D1;
            r_cfg.length_mode     <= 2'd1;
            r_cfg.packet_length   <= 8'd255;
            r_cfg.checksum_enable <= 1'b1;
            r_cfg.tx_off_mode     <= 2'd0;
            r_cfg.autocal_mode    <= 2'd0;
        end else if (i_we) begin
            case (rtfr_pkg::t_reg_idx'(i_idx))
                rtfr_pkg::REG_PREAMBLE_SELECT: r_cfg.preamble_select <= i_data[2:0];
                rtfr_pkg::REG_SYNC_MODE:       r_cfg.sync_mode       <= i_data[2:0];
                rtfr_pkg::REG_SYNC_WORD:       r_cfg.sync_word       <= i_data[15:0];
                rtfr_pkg::REG_LENGTH_MODE:     r_cfg.length_mode     <= i_data[1:0];
                rtfr_pkg::REG_PACKET_LENGTH:   r_cfg.packet_length   <= i_data[7:0];
                rtfr_pkg::REG_CHECKSUM_ENABLE: r_cfg.checksum_enable <= i_data[0];
                rtfr_pkg::REG_TX_OFF_MODE:     r_cfg.tx_off_mode     <= i_data[1:0];
                rtfr_pkg::REG_AUTOCAL_MODE:    r_cfg.autocal_mode    <= i_data[1:0];
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

// ----- rtl/core/rtfr_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rtfr_core
// Framer state and the per-item step: preamble, sync, data, checksum, end.
// ----------------------------------------------------------------------------
module rtfr_core (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_fire,
    input  rtfr_pkg::t_item   i_item,
    input  rtfr_pkg::t_cfg    i_cfg,
    output rtfr_pkg::t_result o_result
);

    localparam int OW = rtfr_pkg::OFF_W;

    rtfr_pkg::t_phase r_phase, n_phase;
    logic [OW-1:0]    r_offset, n_offset;
    logic [OW-1:0]    r_flen, n_flen;
    logic [15:0]      r_sum, n_sum;
    logic             r_uf, n_uf;

    always_comb begin
        logic [OW-1:0] inc_off;
        logic [OW-1:0] flen;
        logic [OW-1:0] off_next;
        logic [1:0]    k;
        logic          dbl;
        logic          inf;
        logic          do_finish;

        n_phase   = r_phase;
        n_offset  = r_offset;
        n_flen    = r_flen;
        n_sum     = r_sum;
        n_uf      = r_uf;
        do_finish = 1'b0;
        inc_off   = rtfr_pkg::off_inc(r_offset);
        k         = r_offset[1:0];
        dbl       = (i_cfg.sync_mode[1:0] == rtfr_pkg::SYNC_DOUBLE);
        inf       = i_cfg.length_mode[1];
        flen      = r_flen;
        off_next  = r_offset;

        o_result.out_byte   = 8'h00;
        o_result.status     = rtfr_pkg::ST_SENT;
        o_result.fifo_pop   = 1'b0;
        o_result.packet_end = 1'b0;
        o_result.end_action = rtfr_pkg::ACT_NONE;

        if (i_item.opcode == rtfr_pkg::OP_START) begin
            n_phase         = rtfr_pkg::PH_PRE;
            n_offset        = '0;
            n_sum           = '0;
            n_uf            = 1'b0;
            o_result.status = rtfr_pkg::ST_NONE;
        end else if (r_uf) begin
            o_result.status = rtfr_pkg::ST_UNDERFLOW;
        end else begin
            case (r_phase)
                rtfr_pkg::PH_PRE: begin
                    o_result.out_byte = rtfr_pkg::PREAMBLE_BYTE;
                    n_offset          = inc_off;
                    if (inc_off >= {{(OW-5){1'b0}}, rtfr_pkg::pre_count(i_cfg.preamble_select)}
                        && i_item.fifo_has_byte) begin
                        n_phase  = (i_cfg.sync_mode[1:0] == rtfr_pkg::SYNC_NONE) ?
                                   rtfr_pkg::PH_DATA : rtfr_pkg::PH_SYNC;
                        n_offset = '0;
                    end
                end
                rtfr_pkg::PH_SYNC: begin
                    o_result.out_byte = k[0] ? i_cfg.sync_word[7:0] : i_cfg.sync_word[15:8];
                    if ((k == 2'd1 && !dbl) || k == 2'd3) begin
                        n_phase  = rtfr_pkg::PH_DATA;
                        n_offset = '0;
                    end else begin
                        n_offset = {{(OW-2){1'b0}}, k} + 1'b1;
                    end
                end
                rtfr_pkg::PH_DATA: begin
                    if (!i_item.fifo_has_byte) begin
                        n_uf            = 1'b1;
                        o_result.status = rtfr_pkg::ST_UNDERFLOW;
                    end else begin
                        if (i_cfg.length_mode == rtfr_pkg::LEN_FIXED) begin
                            flen = {{(OW-8){1'b0}}, i_cfg.packet_length};
                        end else if (i_cfg.length_mode == rtfr_pkg::LEN_VARIABLE
                                     && r_offset == '0) begin
                            flen = {{(OW-8){1'b0}}, i_item.fifo_byte} + 1'b1;
                        end
                        n_flen            = flen;
                        o_result.out_byte = i_item.fifo_byte;
                        o_result.fifo_pop = 1'b1;
                        off_next          = inf ? r_offset : inc_off;
                        n_offset          = off_next;
                        n_sum             = r_sum + {8'h00, i_item.fifo_byte};
                        if (!inf && off_next == flen) begin
                            if (i_cfg.checksum_enable) begin
                                n_phase  = rtfr_pkg::PH_SUM;
                                n_offset = '0;
                            end else begin
                                do_finish = 1'b1;
                            end
                        end
                    end
                end
                rtfr_pkg::PH_SUM: begin
                    if (r_offset == '0) begin
                        o_result.out_byte = r_sum[15:8];
                        n_offset          = {{(OW-1){1'b0}}, 1'b1};
                    end else begin
                        o_result.out_byte = r_sum[7:0];
                        do_finish         = 1'b1;
                    end
                end
                default: begin
                    o_result.status = rtfr_pkg::ST_NONE;
                end
            endcase
        end

        // packet close and end action
        if (do_finish) begin
            o_result.packet_end = 1'b1;
            n_phase             = rtfr_pkg::PH_DONE;
            n_offset            = '0;
            case (i_cfg.tx_off_mode)
                rtfr_pkg::TXOFF_IDLE: begin
                    o_result.end_action = i_cfg.autocal_mode[1] ?
                                          rtfr_pkg::ACT_CALIBRATE : rtfr_pkg::ACT_IDLE;
                end
                rtfr_pkg::TXOFF_FSTXON: begin
                    o_result.end_action = rtfr_pkg::ACT_FSTXON;
                end
                rtfr_pkg::TXOFF_RESTART: begin
                    o_result.end_action = rtfr_pkg::ACT_RESTART;
                    n_phase             = rtfr_pkg::PH_PRE;
                    n_sum               = '0;
                end
                default: begin
                    o_result.end_action = rtfr_pkg::ACT_RX;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= rtfr_pkg::PH_DONE;
            r_offset <= '0;
            r_flen   <= '0;
            r_sum    <= '0;
            r_uf     <= 1'b0;
        end else if (i_fire) begin
            r_phase  <= n_phase;
            r_offset <= n_offset;
            r_flen   <= n_flen;
            r_sum    <= n_sum;
            r_uf     <= n_uf;
        end
    end

endmodule

// ----- tb/radio_tx_packet_framer_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// radio_tx_packet_framer_checker
// Watches the request, result and register-write ports of the transmit
// framer, keeps its own copy of the framer state and registers, works out
// the byte each accepted request must produce and compares every returned
// result field by field against the oldest outstanding prediction.
// ----------------------------------------------------------------------------
module radio_tx_packet_framer_checker (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    rtfr_req_if                             i_req,
    rtfr_rsp_if                             i_rsp,
    input  logic                            i_cfg_we,
    input  logic [rtfr_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [rtfr_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output int                              o_fail_count,
    output int                              o_pending
);
    import rtfr_pkg::*;

    localparam logic [39:0] PREAMBLE_LENS =
        {5'd24, 5'd16, 5'd12, 5'd8, 5'd6, 5'd4, 5'd3, 5'd2};
    localparam int REPORT_LIMIT = 10;

    t_cfg       cfg;
    t_phase     phase;
    logic [8:0] offset;
    logic [8:0] frame_len;
    logic [15:0] byte_sum;
    logic       underflow;
    t_result    expected_tx_q[$];
    int         fail_count = 0;

    function automatic logic [8:0] sat_inc(input logic [8:0] v);
        sat_inc = (v == 9'h1FF) ? v : v + 9'd1;
    endfunction

    task automatic close_packet(inout t_result res);
        res.packet_end = 1'b1;
        phase = PH_DONE;
        offset = '0;
        case (cfg.tx_off_mode)
            TXOFF_IDLE: begin
                res.end_action = cfg.autocal_mode[1] ? ACT_CALIBRATE : ACT_IDLE;
            end
            TXOFF_FSTXON: res.end_action = ACT_FSTXON;
            TXOFF_RESTART: begin
                phase = PH_PRE;
                byte_sum = '0;
                res.end_action = ACT_RESTART;
            end
            default: res.end_action = ACT_RX;
        endcase
    endtask

    task automatic predict_tx_byte(input t_item req, output t_result res);
        logic [1:0] k;
        logic       two_sync;
        logic       endless;
        res = '0;
        res.status = ST_SENT;
        res.end_action = ACT_NONE;
        two_sync = (cfg.sync_mode[1:0] == SYNC_DOUBLE);
        if (req.opcode == OP_START) begin
            phase = PH_PRE;
            offset = '0;
            byte_sum = '0;
            underflow = 1'b0;
            res.status = ST_NONE;
        end else if (underflow) begin
            res.status = ST_UNDERFLOW;
        end else begin
            case (phase)
                PH_PRE: begin
                    res.out_byte = PREAMBLE_BYTE;
                    offset = sat_inc(offset);
                    if (offset >= PREAMBLE_LENS[cfg.preamble_select*5 +: 5] &&
                        req.fifo_has_byte) begin
                        phase = (cfg.sync_mode[1:0] == SYNC_NONE) ? PH_DATA : PH_SYNC;
                        offset = '0;
                    end
                end
                PH_SYNC: begin
                    k = offset[1:0];
                    res.out_byte = k[0] ? cfg.sync_word[7:0] : cfg.sync_word[15:8];
                    if ((k == 2'd1 && !two_sync) || k == 2'd3) begin
                        phase = PH_DATA;
                        offset = '0;
                    end else begin
                        offset = {7'd0, k} + 9'd1;
                    end
                end
                PH_DATA: begin
                    if (!req.fifo_has_byte) begin
                        underflow = 1'b1;
                        res.status = ST_UNDERFLOW;
                    end else begin
                        endless = cfg.length_mode[1];
                        if (cfg.length_mode == LEN_FIXED)
                            frame_len = {1'b0, cfg.packet_length};
                        else if (cfg.length_mode == LEN_VARIABLE && offset == '0)
                            frame_len = {1'b0, req.fifo_byte} + 9'd1;
                        res.out_byte = req.fifo_byte;
                        res.fifo_pop = 1'b1;
                        if (!endless)
                            offset = sat_inc(offset);
                        byte_sum = byte_sum + {8'd0, req.fifo_byte};
                        if (!endless && offset == frame_len) begin
                            if (cfg.checksum_enable) begin
                                phase = PH_SUM;
                                offset = '0;
                            end else begin
                                close_packet(res);
                            end
                        end
                    end
                end
                PH_SUM: begin
                    if (offset == '0) begin
                        res.out_byte = byte_sum[15:8];
                        offset = 9'd1;
                    end else begin
                        res.out_byte = byte_sum[7:0];
                        close_packet(res);
                    end
                end
                default: res.status = ST_NONE;
            endcase
        end
    endtask

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got) begin
            fail_count++;
            if (fail_count <= REPORT_LIMIT)
                $display("%0t: %s mismatch, expected %0d, got %0d",
                         $time, name, want, got);
        end
    endtask

    always @(posedge i_clk) begin : monitor
        t_item   req_item;
        t_result want;
        t_result got;
        if (!i_rst_n) begin
            cfg = {3'd2, 3'd2, 16'hD9D1, LEN_VARIABLE, 8'd255, 1'b1, TXOFF_IDLE, 2'd0};
            phase = PH_DONE;
            offset = '0;
            frame_len = '0;
            byte_sum = '0;
            underflow = 1'b0;
            expected_tx_q.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_PREAMBLE_SELECT: cfg.preamble_select = i_cfg_data[2:0];
                    REG_SYNC_MODE:       cfg.sync_mode = i_cfg_data[2:0];
                    REG_SYNC_WORD:       cfg.sync_word = i_cfg_data;
                    REG_LENGTH_MODE:     cfg.length_mode = i_cfg_data[1:0];
                    REG_PACKET_LENGTH:   cfg.packet_length = i_cfg_data[7:0];
                    REG_CHECKSUM_ENABLE: cfg.checksum_enable = i_cfg_data[0];
                    REG_TX_OFF_MODE:     cfg.tx_off_mode = i_cfg_data[1:0];
                    default:             cfg.autocal_mode = i_cfg_data[1:0];
                endcase
            end
            if (i_rsp.valid && i_rsp.ready) begin
                got.out_byte = i_rsp.out_byte;
                got.status = i_rsp.status;
                got.fifo_pop = i_rsp.fifo_pop;
                got.packet_end = i_rsp.packet_end;
                got.end_action = i_rsp.end_action;
                if (expected_tx_q.size() == 0) begin
                    fail_count++;
                    if (fail_count <= REPORT_LIMIT)
                        $display("%0t: unexpected result, byte %0d status %0d",
                                 $time, got.out_byte, got.status);
                end else begin
                    want = expected_tx_q.pop_front();
                    check_field("out_byte", want.out_byte, got.out_byte);
                    check_field("status", want.status, got.status);
                    check_field("fifo_pop", want.fifo_pop, got.fifo_pop);
                    check_field("packet_end", want.packet_end, got.packet_end);
                    check_field("end_action", want.end_action, got.end_action);
                end
            end
            if (i_req.valid && i_req.ready) begin
                req_item.opcode = i_req.opcode;
                req_item.fifo_has_byte = i_req.fifo_has_byte;
                req_item.fifo_byte = i_req.fifo_byte;
                predict_tx_byte(req_item, want);
                expected_tx_q.push_back(want);
            end
        end
        o_fail_count <= fail_count;
        o_pending <= expected_tx_q.size();
    end

endmodule

// ----- tb/radio_tx_packet_framer_top_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// radio_tx_packet_framer_top_test
// Drives the transmit framer with a short directed sequence and then with
// randomized packets over a series of register settings, with random gaps
// on both channels and one long result hold-off; the checker beside the
// framer predicts and compares, and this module gives the verdict.
// ----------------------------------------------------------------------------
module radio_tx_packet_framer_top_test;
    import rtfr_pkg::*;

    localparam logic [39:0] PREAMBLE_LENS =
        {5'd24, 5'd16, 5'd12, 5'd8, 5'd6, 5'd4, 5'd3, 5'd2};
    localparam logic [1:0] LEN_ENDLESS  = 2'd2;
    localparam logic [1:0] LEN_RESERVED = 2'd3;
    localparam int PHASE_COUNT = 14;
    localparam int PHASE_ITEMS = 60;
    localparam int HOLD_CYCLES = 300;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_idx;
    logic [CFG_DATA_W-1:0] cfg_data;
    int                    fail_count;
    int                    pending;
    int                    idle_pct = 0;
    int                    stall_pct = 0;
    int                    hold_requests = 0;
    int                    hold_served = 0;
    int                    sent_count = 0;
    t_cfg                  cur_cfg;

    rtfr_req_if req_ch ();
    rtfr_rsp_if rsp_ch ();

    radio_tx_packet_framer_top dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_req      (req_ch),
        .o_rsp      (rsp_ch),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    radio_tx_packet_framer_checker checker_i (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_req        (req_ch),
        .i_rsp        (rsp_ch),
        .i_cfg_we     (cfg_we),
        .i_cfg_idx    (cfg_idx),
        .i_cfg_data   (cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    initial begin
        #5_000_000;
        $display("Test completed with failures");
        $finish;
    end

    // result side: random stalls, plus a long hold-off when asked
    initial begin
        rsp_ch.ready = 1'b0;
        forever begin
            @(negedge clk);
            if (hold_served != hold_requests) begin
                rsp_ch.ready = 1'b0;
                repeat (HOLD_CYCLES - 1) @(negedge clk);
                hold_served++;
            end else begin
                rsp_ch.ready = ($urandom_range(99) >= stall_pct);
            end
        end
    end

    task automatic send_req(input logic op, input logic has, input logic [7:0] data);
        while ($urandom_range(99) < idle_pct) begin
            req_ch.valid = 1'b0;
            @(negedge clk);
        end
        req_ch.valid = 1'b1;
        req_ch.opcode = op;
        req_ch.fifo_has_byte = has;
        req_ch.fifo_byte = data;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
        @(negedge clk);
        sent_count++;
    endtask

    task automatic drain();
        req_ch.valid = 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_reg(input t_reg_idx idx, input logic [CFG_DATA_W-1:0] value);
        cfg_we = 1'b1;
        cfg_idx = idx;
        cfg_data = value;
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    task automatic apply_config(input t_cfg c);
        write_reg(REG_PREAMBLE_SELECT, c.preamble_select);
        write_reg(REG_SYNC_MODE, c.sync_mode);
        write_reg(REG_SYNC_WORD, c.sync_word);
        write_reg(REG_LENGTH_MODE, c.length_mode);
        write_reg(REG_PACKET_LENGTH, c.packet_length);
        write_reg(REG_CHECKSUM_ENABLE, c.checksum_enable);
        write_reg(REG_TX_OFF_MODE, c.tx_off_mode);
        write_reg(REG_AUTOCAL_MODE, c.autocal_mode);
        cur_cfg = c;
    endtask

    // start, then enough ticks to run the whole frame plus a few spare
    task automatic send_packet();
        int unsigned lead;
        int unsigned body;
        logic [7:0]  len_byte;
        logic        endless;
        lead = PREAMBLE_LENS[cur_cfg.preamble_select*5 +: 5];
        if (cur_cfg.sync_mode[1:0] == SYNC_DOUBLE)
            lead += 4;
        else if (cur_cfg.sync_mode[1:0] != SYNC_NONE)
            lead += 2;
        case ($urandom_range(19))
            0:             len_byte = 8'hFF;
            1, 2, 3, 4, 5: len_byte = 8'($urandom_range(40, 8));
            default:       len_byte = 8'($urandom_range(7));
        endcase
        endless = cur_cfg.length_mode[1] ||
                  (cur_cfg.length_mode == LEN_FIXED && cur_cfg.packet_length == 8'd0);
        if (endless) begin
            body = $urandom_range(30, 4);
        end else begin
            body = (cur_cfg.length_mode == LEN_FIXED) ? cur_cfg.packet_length : len_byte + 1;
            body += (cur_cfg.checksum_enable ? 2 : 0) + $urandom_range(3);
        end
        send_req(OP_START, 1'($urandom_range(1)), 8'($urandom_range(255)));
        for (int unsigned i = 1; i <= lead + body; i++)
            send_req(($urandom_range(49) == 0) ? OP_START : OP_TICK,
                     $urandom_range(99) != 0,
                     (i == lead + 1) ? len_byte : 8'($urandom_range(255)));
    endtask

    initial begin
        t_cfg next_cfg;
        int   phase_start;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_idx = '0;
        cfg_data = '0;
        req_ch.valid = 1'b0;
        req_ch.opcode = OP_TICK;
        req_ch.fifo_has_byte = 1'b0;
        req_ch.fifo_byte = '0;
        cur_cfg = {3'd2, 3'd2, 16'hD9D1, LEN_VARIABLE, 8'd255, 1'b1, TXOFF_IDLE, 2'd0};
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // reset settings: idle tick, preamble held by empty fifo, short
        // variable frame with checksum, then a data underflow and recovery
        send_req(OP_TICK, 1'b1, 8'hFF);
        send_req(OP_START, 1'b0, 8'h00);
        repeat (5) send_req(OP_TICK, 1'b0, 8'h00);
        send_req(OP_TICK, 1'b1, 8'h00);
        repeat (2) send_req(OP_TICK, 1'b1, 8'h00);
        send_req(OP_TICK, 1'b1, 8'h02);
        send_req(OP_TICK, 1'b1, 8'h00);
        send_req(OP_TICK, 1'b1, 8'hFF);
        repeat (2) send_req(OP_TICK, 1'b1, 8'hAA);
        send_req(OP_TICK, 1'b1, 8'h55);
        send_req(OP_START, 1'b1, 8'hFF);
        repeat (6) send_req(OP_TICK, 1'b1, 8'h0F);
        send_req(OP_TICK, 1'b0, 8'h00);
        send_req(OP_TICK, 1'b1, 8'hF0);
        send_req(OP_START, 1'b0, 8'h00);

        for (int p = 1; p < PHASE_COUNT; p++) begin
            drain();
            case (p % 4)
                0:       begin idle_pct = 0;  stall_pct = 0;  end
                1:       begin idle_pct = 60; stall_pct = 0;  end
                2:       begin idle_pct = 0;  stall_pct = 60; end
                default: begin idle_pct = 35; stall_pct = 35; end
            endcase
            case (p)
                1: next_cfg = {3'd0, 3'd0, 16'h0000, LEN_FIXED, 8'd1, 1'b0, TXOFF_IDLE, 2'd3};
                2: next_cfg = {3'd7, 3'd7, 16'hFFFF, LEN_VARIABLE, 8'd0, 1'b1,
                               TXOFF_FSTXON, 2'd2};
                3: next_cfg = {3'd1, 3'd3, 16'hA5C3, LEN_ENDLESS, 8'd5, 1'b1,
                               TXOFF_RESTART, 2'd1};
                4: next_cfg = {3'd3, 3'd4, 16'h1234, LEN_RESERVED, 8'd9, 1'b0, TXOFF_RX, 2'd0};
                5: next_cfg = {3'd2, 3'd1, 16'($urandom_range(65535)), LEN_FIXED, 8'd0, 1'b1,
                               TXOFF_IDLE, 2'd2};
                6: next_cfg = {3'd0, 3'd0, 16'($urandom_range(65535)), LEN_FIXED, 8'd255, 1'b1,
                               TXOFF_RESTART, 2'd0};
                7: next_cfg = {3'd1, 3'd2, 16'($urandom_range(65535)), LEN_VARIABLE, 8'd0,
                               1'b0, TXOFF_RESTART, 2'd3};
                default: begin
                    next_cfg.preamble_select = 3'($urandom_range(7));
                    next_cfg.sync_mode = 3'($urandom_range(7));
                    next_cfg.sync_word = 16'($urandom_range(65535));
                    next_cfg.length_mode = 2'($urandom_range(3));
                    next_cfg.packet_length = ($urandom_range(7) == 0) ?
                                             8'd0 : 8'($urandom_range(12, 1));
                    next_cfg.checksum_enable = 1'($urandom_range(1));
                    next_cfg.tx_off_mode = 2'($urandom_range(3));
                    next_cfg.autocal_mode = 2'($urandom_range(3));
                end
            endcase
            apply_config(next_cfg);
            if (p == 4)
                hold_requests++;
            phase_start = sent_count;
            while (sent_count - phase_start < PHASE_ITEMS) begin
                if ($urandom_range(9) == 0) begin
                    repeat ($urandom_range(6, 1))
                        send_req(($urandom_range(2) == 0) ? OP_START : OP_TICK,
                                 1'($urandom_range(1)), 8'($urandom_range(255)));
                end else begin
                    send_packet();
                end
            end
        end

        drain();
        repeat (10) @(negedge clk);
        if (fail_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
